/* sv/bdp_pkg.sv */
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared widths, fixed-point constants, coefficient tables and the per-item
// context that travels along the horner cell chain.
// ----------------------------------------------------------------------------
package bdp_pkg;

    // configuration of the evaluator
    localparam int COEFF_COUNT = 16;
    localparam int FRAC_BITS   = 16;
    localparam int TABLE_LEN   = 16;
    localparam int TIDX_W      = $clog2(TABLE_LEN);
    localparam longint DEC_UNIT = 10000;

    // port widths
    localparam int VEL_W   = 32;
    localparam int DIST_W  = 48;
    localparam int OUT_FRAC = 16;

    // internal widths
    localparam int VFW    = FRAC_BITS + 17;          // velocity at FRAC_BITS fraction bits
    localparam int DW     = VFW;                     // velocity minus centre
    localparam int RW     = FRAC_BITS - 4;           // reciprocal of scale, unsigned
    localparam int PRW    = DW + RW + 1;             // normalizing product
    localparam int NMW    = FRAC_BITS + 12;          // magnitude of normalized velocity
    localparam int CW     = FRAC_BITS + 12;          // coefficient, signed
    localparam int AW     = 63;                      // working accumulator, signed
    localparam int AMW    = AW - 1;                  // accumulator magnitude
    localparam int HALF_W = AMW / 2;                 // multiplier split
    localparam int PPW    = HALF_W + NMW;            // partial product
    localparam int PW     = AMW + NMW;               // full product
    localparam int SUM_W  = AW + 1;

    localparam longint RND = 64'sd1 <<< (FRAC_BITS - 1);

    localparam logic [AMW-1:0]          WORK_MAX = {AMW{1'b1}};
    localparam logic signed [AW-1:0]    ACC_MAX  = {1'b0, WORK_MAX};
    localparam logic signed [AW-1:0]    ACC_MIN  = -ACC_MAX;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = {2'b00, WORK_MAX};
    localparam logic signed [SUM_W-1:0] SUM_MIN  = -SUM_MAX;

    localparam logic signed [DIST_W-1:0] OUT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] OUT_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // coefficients in units of 0.0001
    localparam longint SLOW_SET [TABLE_LEN] = '{
        1363132, 1589403, 636093, -354894, -1492755, 1526967, 5025464, -2184689,
        -7795340, 957285, 6211013, 504598, -2450990, -545000, 380642, 123548};
    localparam longint FAST_SET [TABLE_LEN] = '{
        2586000, 2992000, 1152000, -1047000, -2609000, 4885000, 9408000, -8085000,
        -15519000, 5517000, 13157000, -614000, -5514000, -845000, 907000, 262000};

    localparam longint SLOW_CENTRE_DEC = 300079;
    localparam longint SLOW_SCALE      = 172325;
    localparam longint FAST_CENTRE_DEC = 414985;
    localparam longint FAST_SCALE      = 235436;
    localparam longint TWO_DEC         = 20000;

    // decimal constant to fixed point, half away from zero
    function automatic longint dec_to_fix(input longint k);
        longint m;
        longint r;
        m = (k < 0) ? -k : k;
        r = ((m <<< FRAC_BITS) + DEC_UNIT / 2) / DEC_UNIT;
        return (k < 0) ? -r : r;
    endfunction

    function automatic logic signed [CW-1:0] coef_fix(input logic fast,
                                                      input logic [TIDX_W-1:0] idx);
        longint k;
        k = fast ? FAST_SET[idx] : SLOW_SET[idx];
        return CW'(dec_to_fix(k));
    endfunction

    localparam logic signed [VFW-1:0] SLOW_CENTRE = VFW'(dec_to_fix(SLOW_CENTRE_DEC));
    localparam logic signed [VFW-1:0] FAST_CENTRE = VFW'(dec_to_fix(FAST_CENTRE_DEC));
    localparam logic signed [AW-1:0]  TWO_FIX     = AW'(dec_to_fix(TWO_DEC));

    localparam logic [RW-1:0] SLOW_RECIP =
        RW'(((DEC_UNIT <<< FRAC_BITS) + SLOW_SCALE / 2) / SLOW_SCALE);
    localparam logic [RW-1:0] FAST_RECIP =
        RW'(((DEC_UNIT <<< FRAC_BITS) + FAST_SCALE / 2) / FAST_SCALE);

    localparam logic signed [VEL_W-1:0] THRESH = VEL_W'(64'sd50 <<< 16);

    // what an item carries along the cell chain besides the accumulator
    typedef struct packed {
        logic           fast;
        logic           n_neg;
        logic [NMW-1:0] n_mag;
        logic           ovf;
    } bdp_ctx_t;

endpackage

/* sv/bdp_if.sv */
// ----------------------------------------------------------------------------
// bdp_if
// Valid/ready channels: velocity items in, braking distance items out.
// ----------------------------------------------------------------------------
interface bdp_vel_if
    import bdp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] velocity;

    modport source (output valid, output velocity, input ready);
    modport sink   (input valid, input velocity, output ready);
endinterface

interface bdp_dist_if
    import bdp_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance;
    logic                     overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

/* sv/bdp_norm.sv */
// ----------------------------------------------------------------------------
// bdp_norm
// Picks the coefficient set and normalizes the velocity:
// n = round((v - centre) * recip / 2^FRAC_BITS), three register stages.
// ----------------------------------------------------------------------------
module bdp_norm
    import bdp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    feed_valid,
    input  logic signed [VEL_W-1:0] velocity,
    output logic                    pass_valid,
    output bdp_ctx_t                pass_ctx
);

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_fast_reg, s1_fast_next;
    logic signed [DW-1:0]  s1_diff_reg, s1_diff_next;
    logic                  s2_valid_reg;
    logic                  s2_fast_reg;
    logic signed [PRW-1:0] s2_prod_reg, s2_prod_next;
    logic                  s3_valid_reg;
    bdp_ctx_t              s3_ctx_reg, s3_ctx_next;

    logic signed [VFW-1:0] vf;
    logic [RW-1:0]         recip;
    logic                  p_neg;
    logic [PRW-1:0]        p_op;
    logic [PRW-1:0]        p_rnd;

    // velocity to FRAC_BITS fraction bits
    if (FRAC_BITS >= 16) begin : g_vel_up
        assign vf = VFW'(velocity) <<< (FRAC_BITS - 16);
    end
    else begin : g_vel_down
        localparam int S = 16 - FRAC_BITS;
        logic signed [VEL_W:0] v_t;
        logic signed [VEL_W:0] v_sh;
        assign v_t  = $signed({velocity[VEL_W-1], velocity})
                    + $signed((VEL_W + 1)'(64'sd1 <<< (S - 1)))
                    - $signed({{VEL_W{1'b0}}, velocity[VEL_W-1]});
        assign v_sh = v_t >>> S;
        assign vf   = v_sh[VFW-1:0];
    end

    always_comb
    begin
        s1_valid_next = feed_valid;
        s1_fast_next  = !(velocity < THRESH);
        s1_diff_next  = DW'(vf) - DW'(s1_fast_next ? FAST_CENTRE : SLOW_CENTRE);
    end

    assign recip        = s1_fast_reg ? FAST_RECIP : SLOW_RECIP;
    assign s2_prod_next = PRW'(s1_diff_reg) * PRW'($signed({1'b0, recip}));

    // magnitude rounding in one adder: |x| + h = ~x + h + 1 for negative x
    assign p_neg = s2_prod_reg[PRW-1];
    assign p_op  = p_neg ? ~s2_prod_reg : s2_prod_reg;
    assign p_rnd = p_op + (p_neg ? PRW'(RND + 1) : PRW'(RND));

    always_comb
    begin
        s3_ctx_next.fast  = s2_fast_reg;
        s3_ctx_next.n_neg = p_neg;
        s3_ctx_next.n_mag = p_rnd[FRAC_BITS + NMW - 1:FRAC_BITS];
        s3_ctx_next.ovf   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_fast_reg <= s1_fast_next;
            s1_diff_reg <= s1_diff_next;
            s2_fast_reg <= s1_fast_reg;
            s2_prod_reg <= s2_prod_next;
            s3_ctx_reg  <= s3_ctx_next;
        end
    end

    assign pass_valid = s3_valid_reg;
    assign pass_ctx   = s3_ctx_reg;

endmodule

/* sv/bdp_cell.sv */
// ----------------------------------------------------------------------------
// bdp_cell
// One horner step: acc' = sat(round(acc * n / 2^FRAC_BITS) + c).
// Four stages: magnitude, split multiply, combine and round, add coefficient.
// ----------------------------------------------------------------------------
module bdp_cell
    import bdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 feed_valid,
    input  bdp_ctx_t             feed_ctx,
    input  logic signed [AW-1:0] feed_acc,
    input  logic signed [CW-1:0] coef_slow,
    input  logic signed [CW-1:0] coef_fast,
    output logic                 pass_valid,
    output bdp_ctx_t             pass_ctx,
    output logic signed [AW-1:0] pass_acc
);

    logic                 a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    bdp_ctx_t             a_ctx_reg, b_ctx_reg, c_ctx_reg, d_ctx_reg;
    bdp_ctx_t             c_ctx_next, d_ctx_next;
    logic [AMW-1:0]       a_mag_reg, a_mag_next;
    logic                 a_neg_reg, a_neg_next, b_neg_reg, c_neg_reg;
    logic [PPW-1:0]       b_lo_reg, b_lo_next, b_hi_reg, b_hi_next;
    logic [AMW-1:0]       c_mag_reg, c_mag_next;
    logic signed [AW-1:0] d_acc_reg, d_acc_next;

    logic signed [AW-1:0]    acc_abs;
    logic [PW-1:0]           c_prod;
    logic [PW-FRAC_BITS-1:0] c_quot;
    logic                    c_over;
    logic signed [SUM_W-1:0] d_coef, d_mag, d_sum;
    logic                    d_over;

    // stage a: accumulator magnitude and product sign
    assign acc_abs    = feed_acc[AW-1] ? -feed_acc : feed_acc;
    assign a_mag_next = acc_abs[AMW-1:0];
    assign a_neg_next = feed_acc[AW-1] ^ feed_ctx.n_neg;

    // stage b: two half-width partial products
    assign b_lo_next = PPW'(a_mag_reg[HALF_W-1:0]) * PPW'(a_ctx_reg.n_mag);
    assign b_hi_next = PPW'(a_mag_reg[AMW-1:HALF_W]) * PPW'(a_ctx_reg.n_mag);

    // stage c: combine, round half up on the magnitude, clamp
    assign c_prod = {b_hi_reg, {HALF_W{1'b0}}} + PW'(b_lo_reg) + PW'(RND);
    assign c_quot = c_prod[PW-1:FRAC_BITS];
    assign c_over = |c_quot[PW-FRAC_BITS-1:AMW];

    always_comb
    begin
        c_mag_next     = c_over ? WORK_MAX : c_quot[AMW-1:0];
        c_ctx_next     = b_ctx_reg;
        c_ctx_next.ovf = b_ctx_reg.ovf | c_over;
    end

    // stage d: signed add of the coefficient, then working saturation
    assign d_coef = SUM_W'(c_ctx_reg.fast ? coef_fast : coef_slow);
    assign d_mag  = $signed({2'b00, c_mag_reg});
    assign d_sum  = c_neg_reg ? d_coef - d_mag : d_coef + d_mag;

    always_comb
    begin
        d_over = 1'b0;
        priority if (d_sum > SUM_MAX)
        begin
            d_acc_next = ACC_MAX;
            d_over     = 1'b1;
        end
        else if (d_sum < SUM_MIN)
        begin
            d_acc_next = ACC_MIN;
            d_over     = 1'b1;
        end
        else
        begin
            d_acc_next = d_sum[AW-1:0];
        end
        d_ctx_next     = c_ctx_reg;
        d_ctx_next.ovf = c_ctx_reg.ovf | d_over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= feed_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctx_reg <= feed_ctx;
            a_mag_reg <= a_mag_next;
            a_neg_reg <= a_neg_next;
            b_ctx_reg <= a_ctx_reg;
            b_neg_reg <= a_neg_reg;
            b_lo_reg  <= b_lo_next;
            b_hi_reg  <= b_hi_next;
            c_ctx_reg <= c_ctx_next;
            c_neg_reg <= b_neg_reg;
            c_mag_reg <= c_mag_next;
            d_ctx_reg <= d_ctx_next;
            d_acc_reg <= d_acc_next;
        end
    end

    assign pass_valid = d_valid_reg;
    assign pass_ctx   = d_ctx_reg;
    assign pass_acc   = d_acc_reg;

endmodule

/* sv/bdp_out.sv */
// ----------------------------------------------------------------------------
// bdp_out
// Adds the 2.0 offset, rescales to the output format, saturates, and holds
// results in a two-entry output queue that decouples the pipeline stall.
// ----------------------------------------------------------------------------
module bdp_out
    import bdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 feed_valid,
    input  logic                 feed_ovf,
    input  logic signed [AW-1:0] feed_acc,
    output logic                 advance,
    bdp_dist_if.source           brake
);

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     ovf;
    } bdp_res_t;

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_FULL  = 2'd2;

    logic                    f1_valid_reg;
    logic                    f1_ovf_reg, f1_ovf_next;
    logic signed [AW-1:0]    f1_acc_reg, f1_acc_next;
    logic signed [SUM_W-1:0] f1_sum;

    logic [1:0] fill_reg, fill_next;
    bdp_res_t   ent0_reg, ent0_next, ent1_reg, ent1_next;
    bdp_res_t   res;

    logic                     rng_bad;
    logic signed [DIST_W-1:0] y;
    logic                     push, pop;

    // offset and working saturation
    assign f1_sum = SUM_W'(feed_acc) + SUM_W'(TWO_FIX);

    always_comb
    begin
        f1_ovf_next = feed_ovf;
        priority if (f1_sum > SUM_MAX)
        begin
            f1_acc_next = ACC_MAX;
            f1_ovf_next = 1'b1;
        end
        else if (f1_sum < SUM_MIN)
        begin
            f1_acc_next = ACC_MIN;
            f1_ovf_next = 1'b1;
        end
        else
        begin
            f1_acc_next = f1_sum[AW-1:0];
        end
    end

    // rescale to the output fraction width
    if (FRAC_BITS == OUT_FRAC) begin : g_same
        assign rng_bad = (f1_acc_reg > AW'(OUT_MAX)) || (f1_acc_reg < AW'(OUT_MIN));
        assign y       = f1_acc_reg[DIST_W-1:0];
    end
    else if (FRAC_BITS > OUT_FRAC) begin : g_down
        localparam int S = FRAC_BITS - OUT_FRAC;
        logic signed [AW:0] t;
        logic signed [AW:0] ys;
        assign t  = $signed({f1_acc_reg[AW-1], f1_acc_reg})
                  + $signed((AW + 1)'(64'sd1 <<< (S - 1)))
                  - $signed({{AW{1'b0}}, f1_acc_reg[AW-1]});
        assign ys = t >>> S;
        assign rng_bad = (ys > (AW + 1)'(OUT_MAX)) || (ys < (AW + 1)'(OUT_MIN));
        assign y       = ys[DIST_W-1:0];
    end
    else begin : g_up
        localparam int S = OUT_FRAC - FRAC_BITS;
        localparam logic signed [AW-1:0] LIM = AW'(OUT_MAX) >>> S;
        assign rng_bad = (f1_acc_reg > LIM) || (f1_acc_reg < -LIM);
        assign y       = f1_acc_reg[DIST_W-1:0] <<< S;
    end

    always_comb
    begin
        res.ovf      = f1_ovf_reg | rng_bad;
        res.distance = res.ovf ? (f1_acc_reg[AW-1] ? OUT_MIN : OUT_MAX) : y;
    end

    // two-entry output queue
    assign advance = (fill_reg != FILL_FULL);
    assign push    = advance && f1_valid_reg;
    assign pop     = (fill_reg != FILL_EMPTY) && brake.ready;

    always_comb
    begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        fill_next = fill_reg;
        if (pop)
        begin
            ent0_next = (fill_reg == FILL_FULL) ? ent1_reg : res;
        end
        else if (push && (fill_reg == FILL_EMPTY))
        begin
            ent0_next = res;
        end
        if (push && !pop && (fill_reg == FILL_ONE))
        begin
            ent1_next = res;
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            fill_reg     <= FILL_EMPTY;
        end
        else
        begin
            if (advance)
            begin
                f1_valid_reg <= feed_valid;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_acc_reg <= f1_acc_next;
            f1_ovf_reg <= f1_ovf_next;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign brake.valid    = (fill_reg != FILL_EMPTY);
    assign brake.distance = ent0_reg.distance;
    assign brake.overflow = ent0_reg.ovf;

endmodule

/* sv/braking_distance_polynomial_top.sv */
// throughput: one velocity item per cycle, one result item per input item
// the pipeline stalls only when the two-entry output queue is full
// reset: asynchronous, active low; clears all valid bits and the output queue
// ----------------------------------------------------------------------------
// braking_distance_polynomial_top
// Braking distance from forward velocity: normalize, then a chain of horner
// cells evaluating a degree-15 polynomial, then offset, rescale and saturate.
// ----------------------------------------------------------------------------
module braking_distance_polynomial_top
    import bdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bdp_vel_if.sink    vel,
    bdp_dist_if.source brake
);

    // global advance: every stage moves together, held only by the output queue
    logic adv;

    // chain taps: index 0 leaves the normalizer, index COEFF_COUNT enters the output
    logic                 cv   [COEFF_COUNT+1];
    bdp_ctx_t             cctx [COEFF_COUNT+1];
    logic signed [AW-1:0] cacc [COEFF_COUNT+1];

    assign vel.ready = adv;

    // front end: set selection and normalized velocity (3 stages)
    bdp_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .feed_valid (vel.valid),
        .velocity   (vel.velocity),
        .pass_valid (cv[0]),
        .pass_ctx   (cctx[0])
    );

    // horner starts from zero; the first cell then yields the top coefficient
    assign cacc[0] = '0;

    // one cell per coefficient, highest order first (4 stages each)
    for (genvar k = 0; k < COEFF_COUNT; k++) begin : g_cell
        localparam int IDX = COEFF_COUNT - 1 - k;
        // coefficients past the table are zero
        localparam logic signed [CW-1:0] C_SLOW =
            (IDX < TABLE_LEN) ? coef_fix(1'b0, TIDX_W'(IDX)) : '0;
        localparam logic signed [CW-1:0] C_FAST =
            (IDX < TABLE_LEN) ? coef_fix(1'b1, TIDX_W'(IDX)) : '0;

        bdp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .feed_valid (cv[k]),
            .feed_ctx   (cctx[k]),
            .feed_acc   (cacc[k]),
            .coef_slow  (C_SLOW),
            .coef_fast  (C_FAST),
            .pass_valid (cv[k+1]),
            .pass_ctx   (cctx[k+1]),
            .pass_acc   (cacc[k+1])
        );
    end

    // back end: +2.0, rescale, saturate, output queue
    bdp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (cv[COEFF_COUNT]),
        .feed_ovf   (cctx[COEFF_COUNT].ovf),
        .feed_acc   (cacc[COEFF_COUNT]),
        .advance    (adv),
        .brake      (brake)
    );

`ifndef SYNTHESIS
    // a flagged item always carries one of the two saturation values
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        brake.valid && brake.overflow |->
            (brake.distance == OUT_MAX) || (brake.distance == OUT_MIN))
        else $error("overflow item without saturated distance");

    // a stalled chain keeps its last item in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && cv[COEFF_COUNT] |=> cv[COEFF_COUNT] && $stable(cacc[COEFF_COUNT]))
        else $error("cell chain moved while stalled");

    // input is refused only while results are waiting on the output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vel.ready |-> brake.valid)
        else $error("input stalled with no result pending");
`endif

endmodule

/* tb/braking_distance_polynomial_top_tb.sv */
// ----------------------------------------------------------------------------
// braking_distance_polynomial_top_tb
// Drives velocity items into the braking distance evaluator and checks every
// distance item and overflow flag against a fixed-point horner predictor
// kept in the bench. Both channels idle and stall at random; the output side
// holds off for a long stretch once, and the input side pauses until drained.
// ----------------------------------------------------------------------------
module braking_distance_polynomial_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bdp_pkg::VEL_W;
    import bdp_pkg::DIST_W;

    // fixed-point format and polynomial size of the evaluator
    localparam int FB        = 16;
    localparam int NUM_TERMS = 16;

    // drain wait for the pipeline (a margin is added at the end), hold-off, watchdog
    localparam int LATENCY      = 68;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;

    localparam longint WORK_LIM = (64'sd1 <<< 62) - 1;
    localparam longint DIST_HI  = (64'sd1 <<< 47) - 1;
    localparam longint DIST_LO  = -(64'sd1 <<< 47);

    // speed at which the fast coefficient set takes over, Q16.16
    localparam longint SWITCH_SPEED = 64'sd50 <<< 16;

    // decimal constants in units of 0.0001
    localparam longint SLOW_TERMS [NUM_TERMS] = '{
        1363132, 1589403, 636093, -354894, -1492755, 1526967, 5025464, -2184689,
        -7795340, 957285, 6211013, 504598, -2450990, -545000, 380642, 123548};
    localparam longint FAST_TERMS [NUM_TERMS] = '{
        2586000, 2992000, 1152000, -1047000, -2609000, 4885000, 9408000, -8085000,
        -15519000, 5517000, 13157000, -614000, -5514000, -845000, 907000, 262000};
    localparam longint SLOW_MID  = 300079;
    localparam longint SLOW_SPAN = 172325;
    localparam longint FAST_MID  = 414985;
    localparam longint FAST_SPAN = 235436;
    localparam longint OFFSET_E4 = 20000;

    // directed velocities: zero, tiny, both field extremes, the switch point and
    // its neighbors, both centres, the realistic band, the overflow region, bit patterns
    localparam logic signed [VEL_W-1:0] EDGE_VELOCITIES [22] = '{
        32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0032_0000,
        32'sh0031_FFFF, 32'sh0032_0001, 32'sh7FFF_FFFF, 32'sh8000_0000,
        32'sh001E_01E6, 32'sh0029_7F9E, 32'sh000A_0000, 32'sh0050_0000,
        32'sh0064_0000, 32'sh0078_0000, 32'sh0096_0000, 32'sh00C8_0000,
        32'shFFF6_0000, 32'shFF9C_0000, 32'sh0000_FFFF, 32'sh5555_5555,
        32'shAAAA_AAAA, 32'sh0001_0000};

    typedef struct {
        logic signed [VEL_W-1:0]  velocity;
        logic signed [DIST_W-1:0] distance;
        logic                     overflow;
    } distance_t;

    logic clk = 1'b0;
    logic rst_n;

    bdp_vel_if  vel_ch ();
    bdp_dist_if dist_ch ();

    braking_distance_polynomial_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .vel   (vel_ch),
        .brake (dist_ch)
    );

    // distances predicted for accepted velocities, oldest first
    distance_t expected_distances [$];

    int mismatches   = 0;
    int idle_pct     = 10;
    int hold_left    = 0;
    int stall_cycles = 0;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // decimal constant to fixed point, half away from zero
    function automatic longint to_fixed(input longint k);
        longint m;
        m = (k < 0) ? -k : k;
        m = ((m <<< FB) + 5000) / 10000;
        return (k < 0) ? -m : m;
    endfunction

    // arithmetic right shift with rounding half away from zero
    function automatic longint round_shift(input longint x, input int s);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint clamp_work(input longint x, inout bit ovf);
        if (x > WORK_LIM)
        begin
            ovf = 1'b1;
            return WORK_LIM;
        end
        if (x < -WORK_LIM)
        begin
            ovf = 1'b1;
            return -WORK_LIM;
        end
        return x;
    endfunction

    // round(a * b / 2^FB), product kept exact in 128 bits, saturated
    function automatic longint scaled_product(input longint a, input longint b,
                                              inout bit ovf);
        logic [127:0] p;
        longint       ma;
        longint       mb;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        p   = (p + (128'd1 << (FB - 1))) >> FB;
        if (p > {64'd0, WORK_LIM})
        begin
            ovf = 1'b1;
            return neg ? -WORK_LIM : WORK_LIM;
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic distance_t predict_distance(input logic signed [VEL_W-1:0] vel);
        distance_t res;
        longint    v;
        longint    mid;
        longint    span;
        longint    recip;
        longint    n;
        longint    acc;
        longint    term;
        bit        fast;
        bit        ovf;
        v    = vel;
        fast = (v >= SWITCH_SPEED);
        mid  = to_fixed(fast ? FAST_MID : SLOW_MID);
        span = fast ? FAST_SPAN : SLOW_SPAN;
        recip = ((64'sd10000 <<< FB) + span / 2) / span;
        n    = round_shift((v - mid) * recip, FB);
        ovf  = 1'b0;
        acc  = 0;
        for (int i = NUM_TERMS - 1; i >= 0; i--)
        begin
            term = to_fixed(fast ? FAST_TERMS[i] : SLOW_TERMS[i]);
            acc  = clamp_work(scaled_product(acc, n, ovf) + term, ovf);
        end
        acc = clamp_work(acc + to_fixed(OFFSET_E4), ovf);
        if (acc > DIST_HI || acc < DIST_LO)
            ovf = 1'b1;
        res.velocity = vel;
        res.overflow = ovf;
        res.distance = DIST_W'(ovf ? ((acc < 0) ? DIST_LO : DIST_HI) : acc);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // monitors and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // every accepted velocity item gets its expected distance queued
    always @(posedge clk)
    begin
        if (rst_n && vel_ch.valid && vel_ch.ready)
            expected_distances.push_back(predict_distance(vel_ch.velocity));
    end

    // every accepted distance item is compared with the oldest expectation
    always @(posedge clk)
    begin
        distance_t want;
        if (rst_n && dist_ch.valid && dist_ch.ready)
        begin
            if (expected_distances.size() == 0)
                report_mismatch($sformatf("distance item 0x%h with nothing expected",
                                          dist_ch.distance));
            else
            begin
                want = expected_distances.pop_front();
                if (dist_ch.distance !== want.distance)
                    report_mismatch($sformatf("velocity 0x%h: distance 0x%h, expected 0x%h",
                                              want.velocity, dist_ch.distance,
                                              want.distance));
                if (dist_ch.overflow !== want.overflow)
                    report_mismatch($sformatf("velocity 0x%h: overflow %b, expected %b",
                                              want.velocity, dist_ch.overflow,
                                              want.overflow));
            end
        end
    end

    // result side: random stalls, or a long hold-off counted down here
    always @(posedge clk)
    begin
        if (!rst_n)
            dist_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            dist_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            dist_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // watchdog on cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if ((vel_ch.valid && vel_ch.ready) || (dist_ch.valid && dist_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // offer one velocity item, with a random gap first, until it is taken
    task automatic send_velocity(input logic signed [VEL_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            vel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vel_ch.valid    <= 1'b1;
        vel_ch.velocity <= v;
        @(posedge clk);
        while (!vel_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        while (expected_distances.size() != 0)
            @(posedge clk);
    endtask

    // mostly physical speeds, the switch region and negatives; a quarter full range
    function automatic logic signed [VEL_W-1:0] pick_velocity();
        int bin;
        bin = $urandom_range(0, 99);
        if (bin < 35)
            return $urandom_range(0, 32'h0064_0000);
        if (bin < 50)
            return $urandom_range(32'h0064_0000, 32'h0104_0000);
        if (bin < 65)
            return 32'h0031_0000 + $urandom_range(0, 32'h0002_0000);
        if (bin < 75)
            return -$urandom_range(0, 32'h0064_0000);
        return $urandom();
    endfunction

    task automatic test_directed();
        foreach (EDGE_VELOCITIES[i])
            send_velocity(EDGE_VELOCITIES[i]);
    endtask

    task automatic test_random_speeds(input int count);
        repeat (count)
            send_velocity(pick_velocity());
    endtask

    task automatic test_full_range(input int count);
        repeat (count)
            send_velocity($urandom());
    endtask

    // result side holds off while items keep coming, so the pipe fills and stalls
    task automatic test_output_holdoff(input int count);
        hold_left = HOLD_CYCLES;
        repeat (count)
            send_velocity(pick_velocity());
    endtask

    // input goes quiet until every result is out, then resumes
    task automatic test_pause_until_drained(input int count);
        vel_ch.valid <= 1'b0;
        @(posedge clk);
        wait_until_drained();
        repeat (count)
            send_velocity(pick_velocity());
    endtask

    // a stretch with no idling on either side
    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        repeat (count)
            send_velocity(pick_velocity());
        idle_pct = 10;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        vel_ch.valid    <= 1'b0;
        vel_ch.velocity <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_speeds(250);
        test_full_range(150);
        test_output_holdoff(120);
        test_pause_until_drained(80);
        test_back_to_back(150);

        vel_ch.valid <= 1'b0;
        wait_until_drained();
        repeat (LATENCY + 16) @(posedge clk);

        if (mismatches == 0 && expected_distances.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/bdp_pkg.sv
sv/bdp_if.sv
sv/bdp_norm.sv
sv/bdp_cell.sv
sv/bdp_out.sv
sv/braking_distance_polynomial_top.sv
tb/braking_distance_polynomial_top_tb.sv
